/* hdl/seven_segment_clock_tile_renderer_core_assert.svh */
// Assertion macros used by the checker file of the clock tile renderer.
`ifndef SEVEN_SEGMENT_CLOCK_TILE_RENDERER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_CLOCK_TILE_RENDERER_CORE_ASSERT_SVH

// Clocked property, quiet while reset is high.
`define SSCR_ASSERT_ON(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define SSCR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/sscr_pkg.sv */
// Types, tile patterns and lookup functions of the clock tile renderer.
`default_nettype none
package sscr_pkg;

   localparam int unsigned DIGIT_COUNT = 4;
   localparam logic [6:0]  DIV_BASE    = 7'd10;
   localparam logic [6:0]  COLON_COL   = 7'd60;
   localparam logic [3:0]  CLEAR_LAST  = 4'd4;
   localparam logic [3:0]  STEP_LAST   = 4'd12;

   localparam logic [63:0] TILE_TL    = 64'hFFFFFFFEFEFCF8E0;
   localparam logic [63:0] TILE_TR    = 64'hE0F8FCFEFEFFFFFF;
   localparam logic [63:0] TILE_BL    = 64'hFFFFFF7F7F3F1F07;
   localparam logic [63:0] TILE_BR    = 64'h071F3F7F7FFFFFFF;
   localparam logic [63:0] TILE_FULL  = 64'hFFFFFFFFFFFFFFFF;
   localparam logic [63:0] TILE_SMALL = 64'h007E7E7E7E7E7E00;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DIVH  = 6'b000010,
      S_DIVM  = 6'b000100,
      S_CLEAR = 6'b001000,
      S_DIGIT = 6'b010000,
      S_COLON = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      T_ZERO,
      T_TL,
      T_TR,
      T_BL,
      T_BR,
      T_FULL,
      T_SMALL
   } tile_sel_type;

   // one candidate tile write of a digit
   typedef struct packed {
      logic         en;
      logic [2:0]   page;
      logic [1:0]   coff;    // column offset in tiles (0, 1 or 2)
      tile_sel_type tile;
   } wr_type;

   // result of the shared divide-by-ten unit
   typedef struct packed {
      logic       done;
      logic [3:0] quot;
      logic [3:0] rem;
   } div_res_type;

   function automatic logic [7:0] glyph(input logic [3:0] idx);
      logic [7:0] g;
      unique case (idx)
         4'h0: g = 8'h3F;
         4'h1: g = 8'h80;
         4'h2: g = 8'h5B;
         4'h3: g = 8'h4F;
         4'h4: g = 8'h66;
         4'h5: g = 8'h6D;
         4'h6: g = 8'h7D;
         4'h7: g = 8'h07;
         4'h8: g = 8'h7F;
         4'h9: g = 8'h6F;
         4'hA: g = 8'h77;
         4'hB: g = 8'h7C;
         4'hC: g = 8'h58;
         4'hD: g = 8'h5E;
         4'hE: g = 8'h79;
         4'hF: g = 8'h71;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   function automatic logic [6:0] digit_col(input logic [1:0] idx);
      logic [6:0] c;
      unique case (idx)
         2'd0: c = 7'd3;
         2'd1: c = 7'd31;
         2'd2: c = 7'd73;
         2'd3: c = 7'd101;
         default: c = 7'd0;
      endcase
      return c;
   endfunction

   function automatic logic [63:0] tile_bits(input tile_sel_type t);
      logic [63:0] b;
      unique case (t)
         T_TL:    b = TILE_TL;
         T_TR:    b = TILE_TR;
         T_BL:    b = TILE_BL;
         T_BR:    b = TILE_BR;
         T_FULL:  b = TILE_FULL;
         T_SMALL: b = TILE_SMALL;
         default: b = 64'd0;
      endcase
      return b;
   endfunction

   function automatic wr_type mk(input logic en, input logic [2:0] page,
                                 input logic [1:0] coff, input tile_sel_type t);
      wr_type w;
      w.en   = en;
      w.page = page;
      w.coff = coff;
      w.tile = t;
      return w;
   endfunction

   // Candidate write number 'step' of a digit with segment mask s.
   function automatic wr_type digit_step(input logic [7:0] s, input logic [3:0] step);
      wr_type w;
      w = mk(1'b0, 3'd0, 2'd0, T_ZERO);
      if (s[7]) begin
         // stroke of the digit one
         unique case (step)
            4'd0:    w = mk(1'b1, 3'd1, 2'd0, T_TL);
            4'd1:    w = mk(1'b1, 3'd1, 2'd1, T_FULL);
            4'd2:    w = mk(1'b1, 3'd2, 2'd1, T_FULL);
            4'd3:    w = mk(1'b1, 3'd3, 2'd1, T_FULL);
            4'd4:    w = mk(1'b1, 3'd4, 2'd1, T_FULL);
            4'd5:    w = mk(1'b1, 3'd5, 2'd1, T_FULL);
            default: w = mk(1'b0, 3'd0, 2'd0, T_ZERO);
         endcase
      end else begin
         unique case (step)
            4'd0:  w = mk(s[0], 3'd1, 2'd1, T_FULL);
            4'd1:  w = mk(s[1], 3'd2, 2'd2, T_FULL);
            4'd2:  w = mk(s[2], 3'd4, 2'd2, T_FULL);
            4'd3:  w = mk(s[3], 3'd5, 2'd1, T_FULL);
            4'd4:  w = mk(s[4], 3'd4, 2'd0, T_FULL);
            4'd5:  w = mk(s[5], 3'd2, 2'd0, T_FULL);
            4'd6:  w = mk(s[6], 3'd3, 2'd1, T_FULL);
            4'd7:  w = mk(s[6] | s[0], 3'd1, 2'd0, T_TL);
            4'd8:  w = mk(s[1] | s[0], 3'd1, 2'd2, T_TR);
            4'd9:  w = mk(s[4] | s[3], 3'd5, 2'd0, T_BL);
            4'd10: w = mk(s[3] | s[2], 3'd5, 2'd2, T_BR);
            4'd11: begin
               // left middle join
               w = mk(s[4] | s[5], 3'd3, 2'd0,
                      (s[4] & s[5]) ? T_FULL : (s[4] ? T_TL : T_BL));
            end
            4'd12: begin
               // right middle join
               w = mk(s[2] | s[1], 3'd3, 2'd2,
                      (s[2] & s[1]) ? T_FULL : (s[2] ? T_TR : T_BR));
            end
            default: w = mk(1'b0, 3'd0, 2'd0, T_ZERO);
         endcase
      end
      return w;
   endfunction

endpackage
`default_nettype wire

/* hdl/sscr_div10.sv */
// Iterative divide-by-ten unit: one subtraction of ten per cycle.
`default_nettype none
module sscr_div10
   import sscr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [6:0]  operand,
   output div_res_type      res
);

   logic       busy_ff, busy_in;
   logic [6:0] rem_ff, rem_in;
   logic [3:0] quot_ff, quot_in;
   logic       more;

   assign more = rem_ff >= DIV_BASE;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      priority if (start) begin
         busy_in = 1'b1;
         rem_in  = operand;
         quot_in = 4'd0;
      end else if (busy_ff && more) begin
         rem_in  = rem_ff - DIV_BASE;
         quot_in = quot_ff + 4'd1;
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign res.done = busy_ff && !more;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff[3:0];

endmodule
`default_nettype wire

/* hdl/seven_segment_clock_tile_renderer_core.sv */
// Top level of the seven-segment clock tile renderer.
//
// One request transaction (hour, minute, colon flag) produces a run of 31 to
// 59 page-buffer write transactions: five page clears (pages 1 to 5), then
// the tiles of the four digits at columns 3, 31, 73 and 101, then the two
// colon tiles at column 60 on pages 2 and 4; tlast marks the second colon
// tile. The shared divide-by-ten unit splits first the hour and then the
// minute into digits, the five clears follow, and every digit then walks
// a fixed list of 13 candidate writes (one per cycle while the output
// register can take a write, skipped when its segment is dark); the two
// colon writes come last. The request side accepts a new transaction only
// while the sequencer is idle; the last result may still wait in the
// output register at that point.
`default_nettype none
module seven_segment_clock_tile_renderer_core
   import sscr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,  // hour[6:0], minute[13:7], colon_on[14], zero[15]
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [79:0] rsp_tdata,  // write_kind[0], page_index[3:1], column[10:4],
                                        // tile_bytes[74:11], zero[79:75]
   output      logic        rsp_tlast   // last
);

   // sequencer state
   state_type   state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  idx_ff, idx_in;
   logic [3:0]  digit_ff [DIGIT_COUNT];
   logic [3:0]  digit_in [DIGIT_COUNT];
   logic [6:0]  minute_ff, minute_in;
   logic        colon_ff, colon_in;

   // output register
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [2:0]  page_ff, page_in;
   logic [6:0]  col_ff, col_in;
   logic [63:0] tile_ff, tile_in;
   logic        last_ff, last_in;

   // shared divider
   logic        div_start;
   logic [6:0]  div_operand;
   div_res_type div_res;

   logic        req_fire;
   logic        slot_free;
   wr_type      wr;

   sscr_div10 u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .operand (div_operand),
      .res     (div_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // the output register can take a new write this cycle
   assign slot_free  = !valid_ff || rsp_tready;

   assign wr = digit_step(glyph(digit_ff[idx_ff]), step_ff);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      idx_in      = idx_ff;
      digit_in    = digit_ff;
      minute_in   = minute_ff;
      colon_in    = colon_ff;
      div_start   = 1'b0;
      div_operand = req_tdata[6:0];

      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      page_in  = page_ff;
      col_in   = col_ff;
      tile_in  = tile_ff;
      last_in  = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // latch the request and start splitting the hour
               minute_in = req_tdata[13:7];
               colon_in  = req_tdata[14];
               div_start = 1'b1;
               state_in  = S_DIVH;
            end
         end
         S_DIVH: begin
            if (div_res.done) begin
               digit_in[0] = div_res.quot;
               digit_in[1] = div_res.rem;
               // reuse the divider for the minute
               div_start   = 1'b1;
               div_operand = minute_ff;
               state_in    = S_DIVM;
            end
         end
         S_DIVM: begin
            if (div_res.done) begin
               digit_in[2] = div_res.quot;
               digit_in[3] = div_res.rem;
               step_in     = 4'd0;
               state_in    = S_CLEAR;
            end
         end
         S_CLEAR: begin
            if (slot_free) begin
               valid_in = 1'b1;
               kind_in  = 1'b0;
               page_in  = step_ff[2:0] + 3'd1;
               col_in   = 7'd0;
               tile_in  = 64'd0;
               last_in  = 1'b0;
               if (step_ff == CLEAR_LAST) begin
                  step_in  = 4'd0;
                  idx_in   = 2'd0;
                  state_in = S_DIGIT;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         S_DIGIT: begin
            if (slot_free) begin
               // a dark segment passes its step without a write
               if (wr.en) begin
                  valid_in = 1'b1;
                  kind_in  = 1'b1;
                  page_in  = wr.page;
                  col_in   = digit_col(idx_ff) + {2'b00, wr.coff, 3'b000};
                  tile_in  = tile_bits(wr.tile);
                  last_in  = 1'b0;
               end
               if (step_ff == STEP_LAST) begin
                  step_in = 4'd0;
                  idx_in  = idx_ff + 2'd1;
                  if (idx_ff == 2'(DIGIT_COUNT - 1)) begin
                     state_in = S_COLON;
                  end
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         S_COLON: begin
            if (slot_free) begin
               valid_in = 1'b1;
               kind_in  = 1'b1;
               page_in  = step_ff[0] ? 3'd4 : 3'd2;
               col_in   = COLON_COL;
               tile_in  = tile_bits(colon_ff ? T_FULL : T_SMALL);
               last_in  = step_ff[0];
               if (step_ff[0]) begin
                  step_in  = 4'd0;
                  state_in = S_IDLE;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 4'd0;
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      digit_ff  <= digit_in;
      minute_ff <= minute_in;
      colon_ff  <= colon_in;
      kind_ff   <= kind_in;
      page_ff   <= page_in;
      col_ff    <= col_in;
      tile_ff   <= tile_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, tile_ff, col_ff, page_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

/* hdl/sscr_checker.sv */
// Port-level checker for the clock tile renderer, bound to the top level.
`default_nettype none
`include "seven_segment_clock_tile_renderer_core_assert.svh"
module sscr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // hold a waiting request transaction
   `SSCR_ASSERT_ON(a_req_hold, req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata), "waiting request changed")

   // hold a stalled result transaction
   `SSCR_ASSERT_ON(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // drop the result valid out of reset
   `SSCR_ASSERT_ALWAYS(a_rst_quiet, reset |=> !rsp_tvalid, "result valid after reset")

   // close the request side while a request is worked on
   `SSCR_ASSERT_ON(a_one_req, req_tvalid && req_tready |=> !req_tready, "request side still open")

   // end every run with a colon tile write
   `SSCR_ASSERT_ON(a_last_colon, rsp_tvalid && rsp_tlast |-> rsp_tdata[0] && rsp_tdata[10:4] == 7'd60 && rsp_tdata[3:1] == 3'd4, "run ends off the colon")

endmodule

bind seven_segment_clock_tile_renderer_core sscr_checker u_sscr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

/* tb/tb_seven_segment_clock_tile_renderer_core.sv */
// Self-checking testbench of the seven-segment clock tile renderer core.
`default_nettype none
module tb_seven_segment_clock_tile_renderer_core;
   import sscr_pkg::*;

   // Give up far beyond the slowest legal run: 178 requests of 59 writes each,
   // every write stalled at the receiver.
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned PHASE_ITEMS  = 40;

   typedef enum logic {
      WR_CLEAR = 1'b0,
      WR_TILE  = 1'b1
   } write_kind_type;

   typedef enum logic [1:0] {
      MODE_STEADY,
      MODE_SENDER_GAPS,
      MODE_RECEIVER_STALLS,
      MODE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic       colon_on;
      logic [6:0] minute;
      logic [6:0] hour;
   } clock_request_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  page;
      logic [6:0]  column;
      logic [63:0] bytes;
      logic        last;
   } tile_write_type;

   // Segment masks for glyphs 0..F; bit 7 selects the stroke of the one.
   localparam logic [7:0] SEG_MASKS [16] = '{
      8'h3F, 8'h80, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'd0;  // hour[6:0], minute[13:7], colon_on[14], zero[15]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // write_kind[0], page_index[3:1], column[10:4],
                                     // tile_bytes[74:11], zero[79:75]
   logic        rsp_tlast;

   clock_request_type requests_pending [$];
   tile_write_type    tile_writes_due [$];
   clock_request_type drv_item;
   idle_mode_type     idle_mode = MODE_STEADY;

   int unsigned cycle_count       = 0;
   int unsigned requests_accepted = 0;
   int unsigned writes_checked    = 0;
   int unsigned mismatch_count    = 0;
   int unsigned leftover;

   seven_segment_clock_tile_renderer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction: expand one request into its ordered list of buffer writes.
   // ---------------------------------------------------------------------
   task automatic put_write(input logic kind, input logic [2:0] page,
                            input logic [6:0] col, input logic [63:0] bytes);
      tile_write_type w;
      w.kind   = kind;
      w.page   = page;
      w.column = col;
      w.bytes  = bytes;
      w.last   = 1'b0;
      tile_writes_due.push_back(w);
   endtask

   task automatic draw_digit(input logic [6:0] col, input logic [7:0] s);
      logic [2:0] r;
      r = 3'd1;
      if (s[7]) begin
         // the one: corner on top, then a full column of solid tiles
         put_write(WR_TILE, r, col, TILE_TL);
         put_write(WR_TILE, r, col + 7'd8, TILE_FULL);
         put_write(WR_TILE, r + 3'd1, col + 7'd8, TILE_FULL);
         put_write(WR_TILE, r + 3'd2, col + 7'd8, TILE_FULL);
         put_write(WR_TILE, r + 3'd3, col + 7'd8, TILE_FULL);
         put_write(WR_TILE, r + 3'd4, col + 7'd8, TILE_FULL);
      end else begin
         // main segments a..g
         if (s[0]) put_write(WR_TILE, r, col + 7'd8, TILE_FULL);
         if (s[1]) put_write(WR_TILE, r + 3'd1, col + 7'd16, TILE_FULL);
         if (s[2]) put_write(WR_TILE, r + 3'd3, col + 7'd16, TILE_FULL);
         if (s[3]) put_write(WR_TILE, r + 3'd4, col + 7'd8, TILE_FULL);
         if (s[4]) put_write(WR_TILE, r + 3'd3, col, TILE_FULL);
         if (s[5]) put_write(WR_TILE, r + 3'd1, col, TILE_FULL);
         if (s[6]) put_write(WR_TILE, r + 3'd2, col + 7'd8, TILE_FULL);
         // rounded corners
         if ((s & 8'h41) != 0) put_write(WR_TILE, r, col, TILE_TL);
         if ((s & 8'h03) != 0) put_write(WR_TILE, r, col + 7'd16, TILE_TR);
         if ((s & 8'h18) != 0) put_write(WR_TILE, r + 3'd4, col, TILE_BL);
         if ((s & 8'h0C) != 0) put_write(WR_TILE, r + 3'd4, col + 7'd16, TILE_BR);
         // middle joins, solid where both neighbors are lit
         if (s[5:4] == 2'b11) begin
            put_write(WR_TILE, r + 3'd2, col, TILE_FULL);
         end else begin
            if (s[4]) put_write(WR_TILE, r + 3'd2, col, TILE_TL);
            if (s[5]) put_write(WR_TILE, r + 3'd2, col, TILE_BL);
         end
         if (s[2:1] == 2'b11) begin
            put_write(WR_TILE, r + 3'd2, col + 7'd16, TILE_FULL);
         end else begin
            if (s[2]) put_write(WR_TILE, r + 3'd2, col + 7'd16, TILE_TR);
            if (s[1]) put_write(WR_TILE, r + 3'd2, col + 7'd16, TILE_BR);
         end
      end
   endtask

   task automatic render_clock_face(input clock_request_type q);
      int          h;
      int          m;
      logic [6:0]  col;
      logic [63:0] ctile;
      h     = int'(q.hour);
      m     = int'(q.minute);
      ctile = q.colon_on ? TILE_FULL : TILE_SMALL;
      for (int p = 1; p <= 5; p++) put_write(WR_CLEAR, p[2:0], 7'd0, 64'd0);
      // tens above 9 (hour or minute of 100 and up) fall on the A, b, C glyphs
      col = 7'd3;
      draw_digit(col, SEG_MASKS[(h / 10) & 15]);
      col = col + 7'd28;
      draw_digit(col, SEG_MASKS[(h % 10) & 15]);
      col = col + 7'd42;
      draw_digit(col, SEG_MASKS[(m / 10) & 15]);
      col = col + 7'd28;
      draw_digit(col, SEG_MASKS[(m % 10) & 15]);
      put_write(WR_TILE, 3'd2, COLON_COL, ctile);
      put_write(WR_TILE, 3'd4, COLON_COL, ctile);
      tile_writes_due[tile_writes_due.size() - 1].last = 1'b1;
   endtask

   function automatic logic roll_percent(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic sender_idles(input idle_mode_type mode);
      case (mode)
         MODE_SENDER_GAPS: return roll_percent(86);
         MODE_BOTH:        return roll_percent(33);
         default:          return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls(input idle_mode_type mode);
      case (mode)
         MODE_RECEIVER_STALLS: return roll_percent(86);
         MODE_BOTH:            return roll_percent(33);
         default:              return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: predict on every accepted request, then offer the next one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'd0;
      end else begin
         if (req_tvalid && req_tready) begin
            render_clock_face(drv_item);
            requests_accepted = requests_accepted + 1;
         end
         // hold the offered transaction until it is taken
         if (!req_tvalid || req_tready) begin
            if (requests_pending.size() != 0 && !sender_idles(idle_mode)) begin
               drv_item = requests_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, drv_item};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare every accepted write with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      tile_write_type got;
      tile_write_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = rsp_tdata[0];
            got.page   = rsp_tdata[3:1];
            got.column = rsp_tdata[10:4];
            got.bytes  = rsp_tdata[74:11];
            got.last   = rsp_tlast;
            writes_checked = writes_checked + 1;
            if (tile_writes_due.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("write %0d arrived with none expected: kind %0d page %0d col %0d %h last %0d",
                           writes_checked, got.kind, got.page, got.column, got.bytes, got.last);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = tile_writes_due.pop_front();
               if (got.kind !== want.kind || got.page !== want.page ||
                   got.column !== want.column || got.bytes !== want.bytes ||
                   got.last !== want.last) begin
                  if (mismatch_count < MAX_REPORTS) begin
                     $display("write %0d mismatch, expected kind %0d page %0d col %0d %h last %0d",
                              writes_checked, want.kind, want.page, want.column, want.bytes,
                              want.last);
                     $display("   actual kind %0d page %0d col %0d %h last %0d",
                              got.kind, got.page, got.column, got.bytes, got.last);
                  end
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         rsp_tready <= !receiver_stalls(idle_mode);
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_request(input int unsigned hour, input int unsigned minute,
                                input int unsigned colon);
      clock_request_type q;
      q.hour     = hour[6:0];
      q.minute   = minute[6:0];
      q.colon_on = colon[0];
      requests_pending.push_back(q);
   endtask

   // Mostly real clock values, with a share of the full 7-bit range.
   function automatic int unsigned pick_time_value();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 99);
      return $urandom_range(0, 127);
   endfunction

   // Pause the sender until every request is taken and every write has come.
   task automatic wait_for_idle();
      while (requests_pending.size() != 0 || req_tvalid || tile_writes_due.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every glyph 0..9, the one, tens of 10..12.
      idle_mode = MODE_STEADY;
      queue_request(0, 0, 0);
      queue_request(0, 0, 1);
      queue_request(127, 127, 1);
      queue_request(127, 127, 0);
      queue_request(99, 99, 1);
      queue_request(11, 11, 0);
      queue_request(1, 10, 1);
      queue_request(23, 45, 0);
      queue_request(67, 89, 1);
      queue_request(8, 8, 0);
      queue_request(100, 110, 1);
      queue_request(120, 105, 0);
      queue_request(119, 126, 1);
      queue_request(7'h55, 7'h2A, 0);
      queue_request(7'h2A, 7'h55, 1);
      queue_request(12, 34, 0);
      queue_request(56, 70, 1);
      queue_request(81, 19, 0);
      wait_for_idle();

      // Random phases, each with its own idling pattern.
      for (int ph = 0; ph < 4; ph++) begin
         idle_mode = idle_mode_type'(ph);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_request(pick_time_value(), pick_time_value(), $urandom_range(0, 1));
         wait_for_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      leftover = tile_writes_due.size();
      $display("covered %0d clock requests (directed extremes, A/b/C tens, random) in four idling modes",
               requests_accepted);
      $display("checked %0d buffer writes, %0d mismatches, %0d expected writes missing",
               writes_checked, mismatch_count, leftover);
      if (mismatch_count == 0 && leftover == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
